// File: hw/rtl/pwmt_pkg.sv
// Package for the post/wait match table: sizes, entry layout, status and
// kind codes, and the request/response structs between top and engine.
// No dependencies.
`default_nettype none

package pwmt_pkg;

  localparam int DEPTH     = 64;
  localparam int NODE_BITS = 16;
  localparam int TAG_BITS  = 4;
  localparam int TAG_MAX   = 14;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // request kinds as they arrive on the input channel
  localparam logic [2:0] KIND_POST      = 3'd0;
  localparam logic [2:0] KIND_ARRIVE    = 3'd1;
  localparam logic [2:0] KIND_WAIT_TAG  = 3'd2;
  localparam logic [2:0] KIND_WAIT_NODE = 3'd3;
  localparam logic [2:0] KIND_WAIT_ANY  = 3'd4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_WAIT   = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADTAG = 3'd3,
    ST_REMOTE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,  // no table access, status given by decoder
    OP_APPEND = 2'd1,
    OP_DROP   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [NODE_BITS-1:0] node;
  } entry_t;

  typedef struct packed {
    op_t     op;
    logic    use_tag;
    status_t status;
    entry_t  entry;
  } req_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [CNT_W-1:0] count;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/pwmt_engine.sv
// Table engine: notice memory, pending count and the search/compact sequencer.
// Depends on pwmt_pkg.
`default_nettype none

module pwmt_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  input  wire pwmt_pkg::req_t req,
  output logic               req_ready,
  input  wire logic          rsp_take,
  output pwmt_pkg::rsp_t     rsp
);
  import pwmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SRCH  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  entry_t            key_r, key_nxt;
  logic              use_tag_r, use_tag_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  entry_t            rd_data_r;

  entry_t            mem [DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] last_idx;
  logic              hit;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign last_idx = cnt_m1[ADDR_W-1:0];
  assign hit      = (rd_data_r.node == key_r.node) &&
                    (!use_tag_r || (rd_data_r.tag == key_r.tag));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    use_tag_nxt = use_tag_r;
    status_nxt  = status_r;
    rd_idx_nxt  = rd_idx_r;
    wr_en       = 1'b0;
    wr_addr     = rd_idx_r - ADDR_W'(1);
    wr_data     = rd_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          key_nxt     = req.entry;
          use_tag_nxt = req.use_tag;
          state_nxt   = S_DONE;
          unique case (req.op)
            OP_REPORT: status_nxt = req.status;
            OP_APPEND: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = count_r[ADDR_W-1:0];
                wr_data    = req.entry;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = ST_OK;
              end
            end
            OP_DROP: begin
              if (count_r == '0) begin
                status_nxt = ST_WAIT;
              end else begin
                count_nxt  = cnt_m1;
                status_nxt = ST_OK;
              end
            end
            default: begin  // OP_SEARCH, newest entry first
              if (count_r == '0) begin
                status_nxt = ST_WAIT;
              end else begin
                rd_idx_nxt = last_idx;
                state_nxt  = S_SRCH;
              end
            end
          endcase
        end
      end
      S_SRCH: begin
        if (hit) begin
          if (rd_idx_r == last_idx) begin
            count_nxt  = cnt_m1;
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            state_nxt  = S_SHIFT;
          end
        end else if (rd_idx_r == '0) begin
          status_nxt = ST_WAIT;
          state_nxt  = S_DONE;
        end else begin
          rd_idx_nxt = rd_idx_r - ADDR_W'(1);
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves down one slot; next read overlaps
        wr_en = 1'b1;
        if (rd_idx_r == last_idx) begin
          count_nxt  = cnt_m1;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          rd_idx_nxt = rd_idx_r + ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    use_tag_r <= use_tag_nxt;
    status_r  <= status_nxt;
    rd_idx_r  <= rd_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_idx_nxt];
  end

  assign req_ready  = (state_r == S_IDLE);
  assign rsp.valid  = (state_r == S_DONE);
  assign rsp.status = status_r;
  assign rsp.count  = count_r;

endmodule

`default_nettype wire

// File: hw/rtl/post_wait_match_table_unit.sv
// Post/wait match table top level: request decode, own-rank register,
// result register. Depends on pwmt_pkg and pwmt_engine.
//
// Usage:
//  - in_*   : request stream. tuser carries the kind (post, arrival, wait
//             on node and tag, wait on node, wait any); tdata the node and
//             tag. One result comes back on out_* for every request.
//  - out_*  : result stream, status and pending-notice count.
//  - cfg_*  : writes own_rank; always ready, write only while idle.
// Sequence: posts, arrivals, wait-any and rejected requests go from the
//  engine's done state through the result register. A wait scans the notice
//  memory newest first, one read a cycle, then compacts the entries above
//  the match one per cycle. The notice memory has a single read port.
// Throughput: one request in flight; the next is accepted as soon as the
//  engine is idle, even while the previous result still sits in out_*.
// Reset: synchronous, empties the table (count 0) and clears own_rank.
// Stall: a held result stays on out_* unchanged; a finished request waits
//  inside the engine until the result register frees up.
`default_nettype none

module post_wait_match_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] node, [19:16] tag, rest zero
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] status, [9:3] entry_count
  // own_rank write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import pwmt_pkg::*;

  logic [NODE_BITS-1:0] own_rank_r;

  logic                 in_accept;
  logic [2:0]           kind;
  logic [NODE_BITS-1:0] node;
  logic [TAG_BITS-1:0]  tag;
  logic                 bad_tag;
  req_t                 req;
  rsp_t                 rsp;
  logic                 eng_ready;
  logic                 rsp_take;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [6:0]           out_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r <= '0;
    end else if (cfg_valid) begin
      own_rank_r <= NODE_BITS'(cfg_data);
    end
  end

  assign kind    = in_tuser;
  assign node    = NODE_BITS'(in_tdata[15:0]);
  assign tag     = in_tdata[19:16];
  assign bad_tag = (tag > TAG_BITS'(TAG_MAX));

  // decode the request kind into an engine operation
  always_comb begin
    req.op          = OP_REPORT;
    req.use_tag     = 1'b0;
    req.status      = ST_OK;
    req.entry.node  = node;
    req.entry.tag   = tag;
    unique case (kind)
      KIND_POST: begin
        if (bad_tag) begin
          req.status = ST_BADTAG;
        end else if (node == own_rank_r) begin
          req.op = OP_APPEND;
        end else begin
          req.status = ST_REMOTE;  // not for this node, nothing stored
        end
      end
      KIND_ARRIVE: begin
        if (bad_tag) req.status = ST_BADTAG;
        else         req.op     = OP_APPEND;
      end
      KIND_WAIT_TAG: begin
        if (bad_tag) begin
          req.status = ST_BADTAG;
        end else begin
          req.op      = OP_SEARCH;
          req.use_tag = 1'b1;
        end
      end
      KIND_WAIT_NODE: req.op = OP_SEARCH;
      KIND_WAIT_ANY:  req.op = OP_DROP;
      default:        req.status = ST_OK;  // unused kinds: no effect
    endcase
  end

  assign in_tready = eng_ready;
  assign in_accept = in_tvalid && in_tready;

  pwmt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_accept),
    .req       (req),
    .req_ready (eng_ready),
    .rsp_take  (rsp_take),
    .rsp       (rsp)
  );

  // result register; engine hands over when it is empty or draining
  assign rsp_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take && rsp.valid) begin
      out_status_r <= rsp.status;
      out_count_r  <= 7'(rsp.count);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_count_r, out_status_r};

endmodule

`default_nettype wire

// File: hw/rtl/pwmt_checker.sv
// Port-level checker for post_wait_match_table_unit, attached by bind.
// Depends on pwmt_pkg.
`default_nettype none

module pwmt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);
  import pwmt_pkg::*;

  localparam logic [6:0] FULL_CNT = 7'(DEPTH);

  logic [2:0] status;
  logic [6:0] count;

  assign status = out_tdata[2:0];
  assign count  = out_tdata[9:3];

  // one request in flight: in_tready falls after every accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one still in flight");

  // a dropped insert only happens with the table at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status == ST_FULL)) |-> (count == FULL_CNT))
    else $error("full status with table not full");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status == ST_OK || status == ST_WAIT || status == ST_FULL ||
                    status == ST_BADTAG || status == ST_REMOTE))
    else $error("undefined status code");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind post_wait_match_table_unit pwmt_checker u_pwmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
